/* sv/hst_pkg.sv */
// Shared types and constants of the hall sector tracker.
// Used by every module of the block but hst_checker; depends on nothing.
package hst_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int INTERVAL_W   = 16;
    localparam int TIMEOUT_W    = 16;
    localparam int SECTOR_W     = 3;
    localparam int SECTOR_COUNT = 6;
    localparam int PTR_W        = $clog2(SECTOR_COUNT);
    // Common width for comparing the timeout against the counter range
    localparam int LIM_W        = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Hall codes in commutation order: entry i is sector i+1
    localparam logic [SECTOR_W-1:0] HALL_ORDER [SECTOR_COUNT] =
        '{3'd3, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2};

    // APB register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_STALL_TIMEOUT = '0;
    localparam logic [TIMEOUT_W-1:0] STALL_TIMEOUT_RST = 16'd1000;

    typedef logic [SECTOR_W-1:0]   t_sector;
    typedef logic [INTERVAL_W-1:0] t_interval;

    typedef struct packed {
        t_sector                            sector_now;
        t_sector                            sector_prev;
        t_interval                          elapsed;
        logic [SECTOR_COUNT-1:0][INTERVAL_W-1:0] intervals;
        t_sector                            older;
        t_sector                            newer;
        logic                               speed_reset;
    } t_status;

    // Counter-domain value to a 16-bit interval (zero-extend or truncate)
    function automatic t_interval to_interval(input logic [LIM_W-1:0] value);
        return value[INTERVAL_W-1:0];
    endfunction

endpackage

/* sv/hst_sector_map.sv */
// Hall code to sector decoder of the hall sector tracker.
// Depends on hst_pkg (order table).
module hst_sector_map (
    input  hst_pkg::t_sector i_hall_code,
    output hst_pkg::t_sector o_sector
);
    import hst_pkg::*;

    always_comb begin
        // codes outside the table (0 and 7) pass through unchanged
        o_sector = i_hall_code;
        for (int i = 0; i < SECTOR_COUNT; i++) begin
            if (i_hall_code == HALL_ORDER[i]) begin
                o_sector = SECTOR_W'(i + 1);
            end
        end
    end

endmodule

/* sv/hst_timer.sv */
// Commutation timer: tick counter, stall detect, interval ring and sector history.
// Depends on hst_pkg. State registers double as the result register.
module hst_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  hst_pkg::t_sector            i_sector,
    input  logic [hst_pkg::TIMEOUT_W-1:0] i_timeout,
    output hst_pkg::t_status            o_status
);
    import hst_pkg::*;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [PTR_W-1:0]       r_ptr, n_ptr;
    t_sector                r_sector, r_prev, r_older, r_newer;
    t_interval              r_ring [SECTOR_COUNT];
    t_interval              n_ring [SECTOR_COUNT];
    logic                   r_stall;

    logic [LIM_W-1:0]       lim_wide;
    logic [COUNT_WIDTH-1:0] limit;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   stall;
    logic                   change;

    always_comb begin
        lim_wide = (LIM_W'(i_timeout) < LIM_W'(CNT_MAX)) ? LIM_W'(i_timeout) : LIM_W'(CNT_MAX);
        limit    = lim_wide[COUNT_WIDTH-1:0];
        cnt_inc  = (r_count != CNT_MAX) ? COUNT_WIDTH'(r_count + 1'b1) : r_count;
        stall    = (cnt_inc >= limit);
        change   = (i_sector != r_sector);

        n_count = stall ? limit : cnt_inc;
        n_ptr   = r_ptr;
        if (change) begin
            n_ptr = (r_ptr == PTR_W'(SECTOR_COUNT - 1)) ? '0 : PTR_W'(r_ptr + 1'b1);
        end

        for (int k = 0; k < SECTOR_COUNT; k++) begin
            n_ring[k] = stall ? to_interval(LIM_W'(limit)) : r_ring[k];
            // a change on a stall tick stores the timeout into the new slot
            if (change && (n_ptr == PTR_W'(k))) begin
                n_ring[k] = to_interval(LIM_W'(n_count));
            end
        end
        if (change) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_sector <= '0;
            r_prev   <= '0;
            r_older  <= '0;
            r_newer  <= '0;
            r_stall  <= 1'b0;
            for (int k = 0; k < SECTOR_COUNT; k++) begin
                r_ring[k] <= '0;
            end
        end else if (i_advance) begin
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_sector <= i_sector;
            r_prev   <= r_sector;
            r_stall  <= stall;
            for (int k = 0; k < SECTOR_COUNT; k++) begin
                r_ring[k] <= n_ring[k];
            end
            if (change) begin
                r_older <= r_newer;
                r_newer <= i_sector;
            end
        end
    end

    always_comb begin
        o_status.sector_now  = r_sector;
        o_status.sector_prev = r_prev;
        o_status.elapsed     = to_interval(LIM_W'(r_count));
        for (int k = 0; k < SECTOR_COUNT; k++) begin
            o_status.intervals[k] = r_ring[k];
        end
        o_status.older       = r_older;
        o_status.newer       = r_newer;
        o_status.speed_reset = r_stall;
    end

endmodule

/* sv/hall_sector_tracker_top.sv */
// Top level of the hall sector tracker: handshakes, APB register and result valid.
// Depends on hst_pkg, hst_sector_map and hst_timer.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one 3-bit hall code per control
//   tick. Each accepted transaction yields exactly one status transaction on
//   o_out_valid/i_out_ready: mapped sector, previous sector, elapsed ticks, the
//   six commutation intervals, the two-deep sector history and speed_reset.
//   A hall code accepted at a clock edge is shown as a valid result right
//   after it. Throughput is one transaction per cycle while the receiver is
//   ready, set by the single register stage holding tracker state and result.
//   When the receiver stalls the result holds and o_in_ready drops; a new code
//   is taken in the same cycle the pending result is taken.
//   Synchronous reset (i_rst_n low) clears sector, counter, ring pointer,
//   interval ring and history, drops o_out_valid and sets stall_timeout to 1000.
//   stall_timeout sits at APB byte address 0; write it only while idle.
module hall_sector_tracker_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_hall_code,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_sector_now,
    output logic [2:0]                   o_sector_prev,
    output logic [15:0]                  o_elapsed_ticks,
    output logic [15:0]                  o_interval_0,
    output logic [15:0]                  o_interval_1,
    output logic [15:0]                  o_interval_2,
    output logic [15:0]                  o_interval_3,
    output logic [15:0]                  o_interval_4,
    output logic [15:0]                  o_interval_5,
    output logic [2:0]                   o_older_sector,
    output logic [2:0]                   o_newer_sector,
    output logic                         o_speed_reset,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hst_pkg::PADDR_W-1:0]  paddr,
    input  logic [hst_pkg::PDATA_W-1:0]  pwdata,
    output logic [hst_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import hst_pkg::*;

    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 r_out_valid, n_out_valid;
    logic                 in_accept;
    logic                 reg_sel;
    t_sector              sector;
    t_status              status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_STALL_TIMEOUT);
    assign prdata  = reg_sel ? PDATA_W'(r_timeout) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= STALL_TIMEOUT_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_timeout <= pwdata[TIMEOUT_W-1:0];
        end
    end

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    hst_sector_map u_map (
        .i_hall_code (i_hall_code),
        .o_sector    (sector)
    );

    hst_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_accept),
        .i_sector  (sector),
        .i_timeout (r_timeout),
        .o_status  (status)
    );

    assign o_out_valid     = r_out_valid;
    assign o_sector_now    = status.sector_now;
    assign o_sector_prev   = status.sector_prev;
    assign o_elapsed_ticks = status.elapsed;
    assign o_interval_0    = status.intervals[0];
    assign o_interval_1    = status.intervals[1];
    assign o_interval_2    = status.intervals[2];
    assign o_interval_3    = status.intervals[3];
    assign o_interval_4    = status.intervals[4];
    assign o_interval_5    = status.intervals[5];
    assign o_older_sector  = status.older;
    assign o_newer_sector  = status.newer;
    assign o_speed_reset   = status.speed_reset;

endmodule

/* sv/hst_checker.sv */
// Port-level checks of the hall sector tracker, bound to the top level.
// Depends on hall_sector_tracker_top port names; no package use.
module hst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_sector_now,
    input logic [2:0]  o_sector_prev,
    input logic [15:0] o_elapsed_ticks,
    input logic [15:0] o_interval_0,
    input logic [2:0]  o_newer_sector,
    input logic        o_speed_reset
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sector_now)
            && $stable(o_elapsed_ticks))
        else $error("result changed while stalled");

    // an accepted code gives a valid result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // previous sector of a result is the sector shown before it
    a_prev_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_sector_prev == $past(o_sector_now))
        else $error("sector_prev does not follow sector_now");

    // a sector change clears the counter and enters the history
    a_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sector_now != o_sector_prev)
            |-> (o_elapsed_ticks == 16'd0) && (o_newer_sector == o_sector_now))
        else $error("sector change not recorded");

    // a stall without change leaves counter and intervals at the timeout (interval 0 checked)
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_speed_reset && (o_sector_now == o_sector_prev)
            |-> o_interval_0 == o_elapsed_ticks)
        else $error("stall did not load intervals");

endmodule

bind hall_sector_tracker_top hst_checker u_hst_checker (.*);

/* test/hst_status_checker.sv */
// Status checker for the hall sector tracker: predicts every status transaction
// from the accepted hall codes and APB writes and compares it field by field.
// Depends on hst_pkg.
module hst_status_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [2:0]                  i_hall_code,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [2:0]                  i_sector_now,
    input  logic [2:0]                  i_sector_prev,
    input  logic [15:0]                 i_elapsed_ticks,
    input  logic [15:0]                 i_interval_0,
    input  logic [15:0]                 i_interval_1,
    input  logic [15:0]                 i_interval_2,
    input  logic [15:0]                 i_interval_3,
    input  logic [15:0]                 i_interval_4,
    input  logic [15:0]                 i_interval_5,
    input  logic [2:0]                  i_older_sector,
    input  logic [2:0]                  i_newer_sector,
    input  logic                        i_speed_reset,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [hst_pkg::PADDR_W-1:0] i_paddr,
    input  logic [hst_pkg::PDATA_W-1:0] i_pwdata,
    input  logic [hst_pkg::PDATA_W-1:0] i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);
    import hst_pkg::*;

    // Tracker state as the block should hold it
    t_sector                  cur_sector;
    logic [COUNT_WIDTH-1:0]   tick_cnt;
    t_interval                ring [SECTOR_COUNT];
    int                       ring_ptr;
    t_sector                  hist_older;
    t_sector                  hist_newer;
    logic [TIMEOUT_W-1:0]     stall_timeout;

    t_status                  status_q [$];
    t_status                  want;
    logic [SECTOR_COUNT-1:0][INTERVAL_W-1:0] got_iv;

    assign got_iv = {i_interval_5, i_interval_4, i_interval_3,
                     i_interval_2, i_interval_1, i_interval_0};

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic t_sector hall_to_sector(input t_sector code);
        case (code)
            3'd3:    return 3'd1;
            3'd1:    return 3'd2;
            3'd5:    return 3'd3;
            3'd4:    return 3'd4;
            3'd6:    return 3'd5;
            3'd2:    return 3'd6;
            default: return code;   // 0 and 7 are not valid hall states
        endcase
    endfunction

    // One control tick: count, stall test, then sector change
    function automatic t_status advance_tracker(input t_sector code);
        t_status                st;
        t_sector                now;
        logic [COUNT_WIDTH-1:0] limit;
        int                     k;
        now            = hall_to_sector(code);
        st.sector_prev = cur_sector;
        st.speed_reset = 1'b0;
        cur_sector     = now;
        limit = (stall_timeout < CNT_MAX) ? stall_timeout : CNT_MAX;
        if (tick_cnt != CNT_MAX)
            tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= limit) begin
            st.speed_reset = 1'b1;
            tick_cnt       = limit;
            for (k = 0; k < SECTOR_COUNT; k++)
                ring[k] = limit;
        end
        if (now != st.sector_prev) begin
            // pointer moves before the write, so the first interval lands in slot 1
            ring_ptr       = (ring_ptr == SECTOR_COUNT - 1) ? 0 : ring_ptr + 1;
            ring[ring_ptr] = tick_cnt;
            tick_cnt       = '0;
            hist_older     = hist_newer;
            hist_newer     = now;
        end
        st.sector_now = now;
        st.elapsed    = tick_cnt;
        for (k = 0; k < SECTOR_COUNT; k++)
            st.intervals[k] = ring[k];
        st.older = hist_older;
        st.newer = hist_newer;
        return st;
    endfunction

    task automatic check_value(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("checker: %s mismatch, expected %0d got %0d (status %0d)",
                         name, exp_v, act_v, o_checked);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_sector    = '0;
            tick_cnt      = '0;
            for (int k = 0; k < SECTOR_COUNT; k++)
                ring[k] = '0;
            ring_ptr      = 0;
            hist_older    = '0;
            hist_newer    = '0;
            stall_timeout = STALL_TIMEOUT_RST;
            status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready &&
                i_paddr[PADDR_W-1:2] == REG_STALL_TIMEOUT) begin
                if (i_pwrite)
                    stall_timeout = i_pwdata[TIMEOUT_W-1:0];
                else
                    check_value("stall_timeout readback",
                                {{(PDATA_W-TIMEOUT_W){1'b0}}, stall_timeout}, i_prdata);
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("checker: status transaction with nothing expected");
                end else begin
                    want = status_q.pop_front();
                    check_value("sector_now", 32'(want.sector_now), 32'(i_sector_now));
                    check_value("sector_prev", 32'(want.sector_prev), 32'(i_sector_prev));
                    check_value("elapsed_ticks", 32'(want.elapsed), 32'(i_elapsed_ticks));
                    for (int k = 0; k < SECTOR_COUNT; k++)
                        check_value($sformatf("interval_%0d", k), 32'(want.intervals[k]),
                                    32'(got_iv[k]));
                    check_value("older_sector", 32'(want.older), 32'(i_older_sector));
                    check_value("newer_sector", 32'(want.newer), 32'(i_newer_sector));
                    check_value("speed_reset", 32'(want.speed_reset), 32'(i_speed_reset));
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(advance_tracker(i_hall_code));
        end
        o_pending = status_q.size();
    end

endmodule

/* test/tb.sv */
// Testbench top for the hall sector tracker: drives hall codes and APB accesses,
// paces both channels and gives the verdict.
// Depends on hst_pkg, hall_sector_tracker_top and hst_status_checker.
module tb;
    import hst_pkg::*;

    localparam int RX_LONG_HOLD   = 64;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SAT_HOLD_ITEMS = 100;
    localparam logic [PADDR_W-1:0] ADDR_TIMEOUT  = {REG_STALL_TIMEOUT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;   // past the register list

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                in_valid = 1'b0;
    logic [2:0]          hall    = 3'd0;
    logic                out_ready = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;

    logic                in_ready;
    logic                out_valid;
    logic [2:0]          sector_now, sector_prev, older_sector, newer_sector;
    logic [15:0]         elapsed_ticks;
    logic [15:0]         interval_0, interval_1, interval_2;
    logic [15:0]         interval_3, interval_4, interval_5;
    logic                speed_reset;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  fails, pending, checked;
    int                  n_items     = 0;
    int                  rx_hold_req = 0;
    int                  rx_hold_done = 0;
    logic                full_speed  = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hall_sector_tracker_top uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_hall_code(hall),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_sector_now(sector_now), .o_sector_prev(sector_prev),
        .o_elapsed_ticks(elapsed_ticks),
        .o_interval_0(interval_0), .o_interval_1(interval_1), .o_interval_2(interval_2),
        .o_interval_3(interval_3), .o_interval_4(interval_4), .o_interval_5(interval_5),
        .o_older_sector(older_sector), .o_newer_sector(newer_sector),
        .o_speed_reset(speed_reset),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hst_status_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_hall_code(hall),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_sector_now(sector_now), .i_sector_prev(sector_prev),
        .i_elapsed_ticks(elapsed_ticks),
        .i_interval_0(interval_0), .i_interval_1(interval_1), .i_interval_2(interval_2),
        .i_interval_3(interval_3), .i_interval_4(interval_4), .i_interval_5(interval_5),
        .i_older_sector(older_sector), .i_newer_sector(newer_sector),
        .i_speed_reset(speed_reset),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_prdata(prdata), .i_pready(pready),
        .o_fail_count(fails), .o_pending(pending), .o_checked(checked)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_speed) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called and returns at a falling edge
    task automatic send_code(input logic [2:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        hall     = code;
        do @(posedge clk); while (!in_ready);
        n_items++;
        @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        logic [15:0] upper;
        upper = 16'($urandom);
        wait_idle();
        apb_access(1'b1, ADDR_TIMEOUT, {upper, value});
        apb_access(1'b0, ADDR_TIMEOUT, '0);
    endtask

    // Receiver pacing, including two long hold-offs on request
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            if (rx_hold_req != rx_hold_done) begin
                out_ready = 1'b0;
                repeat (RX_LONG_HOLD) @(negedge clk);
                rx_hold_done++;
            end else if (full_speed) begin
                out_ready = 1'b1;
                @(negedge clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_ready = 1'b0;
                    repeat (n) @(negedge clk);
                end
                out_ready = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    end

    initial begin
        #(4 * 1_500_000);
        $display("tb: errors");
        $finish;
    end

    initial begin
        logic [2:0]  directed_codes [12];
        logic [2:0]  code;
        int          cur_timeout;
        int          rand_items;
        int          phases;
        int          pos, dir, dwell, kind, left;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Full lap from reset, wrap of the ring, raw 0 and 7, reversal and a skip
        directed_codes = '{3'd3, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2,
                           3'd3, 3'd0, 3'd7, 3'd2, 3'd6, 3'd3};
        foreach (directed_codes[i])
            send_code(directed_codes[i]);
        repeat (5) send_code(3'd3);

        wait_idle();
        apb_access(1'b0, ADDR_TIMEOUT, '0);
        apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF);
        apb_access(1'b0, ADDR_TIMEOUT, '0);

        // Timeout dropped below the running count: clamps on the next tick
        set_timeout(16'd2);
        repeat (2) send_code(3'd3);
        send_code(3'd1);
        set_timeout(16'd0);
        send_code(3'd1);
        send_code(3'd5);
        send_code(3'd5);
        set_timeout(16'd1);
        send_code(3'd5);
        send_code(3'd4);

        // Long dwell at the widest timeout with no idling on either side
        set_timeout(16'hFFFF);
        full_speed = 1'b1;
        repeat (SAT_HOLD_ITEMS) send_code(3'd4);
        send_code(3'd6);
        full_speed = 1'b0;

        rand_items = 0;
        phases     = 0;
        rx_hold_req++;
        while (rand_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)      cur_timeout = 0;
            else if (kind == 1) cur_timeout = 1;
            else if (kind == 2) cur_timeout = 65535;
            else if (kind == 3) cur_timeout = 1000;
            else                cur_timeout = $urandom_range(2, 40);
            set_timeout(cur_timeout[15:0]);
            if (phases == 0)
                rx_hold_req++;   // long stall while codes keep coming
            phases++;
            left = $urandom_range(40, 120);
            pos  = $urandom_range(0, SECTOR_COUNT - 1);
            dir  = 1;
            while (left > 0) begin
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    if ($urandom_range(0, 9) == 0)
                        dir = -dir;
                    pos  = (pos + dir + SECTOR_COUNT) % SECTOR_COUNT;
                    code = HALL_ORDER[pos];
                end else if (kind < 90) begin
                    code = 3'($urandom_range(0, 7));
                end else begin
                    pos  = (pos + $urandom_range(2, 4)) % SECTOR_COUNT;
                    code = HALL_ORDER[pos];
                end
                if (cur_timeout >= 2 && cur_timeout <= 40)
                    dwell = $urandom_range(1, cur_timeout + 3);
                else if ($urandom_range(0, 19) == 0)
                    dwell = $urandom_range(20, 60);
                else
                    dwell = $urandom_range(1, 8);
                repeat (dwell) send_code(code);
                left       -= dwell;
                rand_items += dwell;
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
            end
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        $display("tb: %0d hall codes sent, %0d status transactions checked, %0d random phases",
                 n_items, checked, phases);
        $display("tb: timeouts 0, 1, 2, 1000 and full scale, long receiver stall, idle drains");
        if (fails == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
sv/hst_pkg.sv
sv/hst_sector_map.sv
sv/hst_timer.sv
sv/hall_sector_tracker_top.sv
sv/hst_checker.sv
test/hst_status_checker.sv
test/tb.sv
